@@ design/rv32i_instruction_decoder_unit_defines.svh @@
// Assertion macros for the instruction decoder checker.
`ifndef RV32I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is applied.
`define RVID_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvid check failed");

// Next-cycle implication.
`define RVID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvid check failed");

`endif

@@ design/rvid_pkg.sv @@
package rvid_pkg;

	// major opcodes
	localparam logic [6:0] OPC_LUI     = 7'h37;
	localparam logic [6:0] OPC_AUIPC   = 7'h17;
	localparam logic [6:0] OPC_JAL     = 7'h6F;
	localparam logic [6:0] OPC_JALR    = 7'h67;
	localparam logic [6:0] OPC_BRANCH  = 7'h63;
	localparam logic [6:0] OPC_LOAD    = 7'h03;
	localparam logic [6:0] OPC_STORE   = 7'h23;
	localparam logic [6:0] OPC_OPIMM   = 7'h13;
	localparam logic [6:0] OPC_OP      = 7'h33;
	localparam logic [6:0] OPC_MISCMEM = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM  = 7'h73;

	localparam logic [6:0]  F7_BASE   = 7'h00;
	localparam logic [6:0]  F7_ALT    = 7'h20;
	localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
	localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

	typedef enum logic [2:0] {
		FMT_NONE = 3'd0,
		FMT_R    = 3'd1,
		FMT_I    = 3'd2,
		FMT_S    = 3'd3,
		FMT_B    = 3'd4,
		FMT_U    = 3'd5,
		FMT_J    = 3'd6
	} fmt_t;

	typedef logic [5:0] op_t;

	localparam op_t OP_NONE    = 6'd0;
	localparam op_t OP_LUI     = 6'd1;
	localparam op_t OP_AUIPC   = 6'd2;
	localparam op_t OP_JAL     = 6'd3;
	localparam op_t OP_JALR    = 6'd4;
	localparam op_t OP_BEQ     = 6'd5;
	localparam op_t OP_BNE     = 6'd6;
	localparam op_t OP_BLT     = 6'd7;
	localparam op_t OP_BGE     = 6'd8;
	localparam op_t OP_BLTU    = 6'd9;
	localparam op_t OP_BGEU    = 6'd10;
	localparam op_t OP_LB      = 6'd11;
	localparam op_t OP_LH      = 6'd12;
	localparam op_t OP_LW      = 6'd13;
	localparam op_t OP_LBU     = 6'd14;
	localparam op_t OP_LHU     = 6'd15;
	localparam op_t OP_SB      = 6'd16;
	localparam op_t OP_SH      = 6'd17;
	localparam op_t OP_SW      = 6'd18;
	localparam op_t OP_ADDI    = 6'd19;
	localparam op_t OP_SLTI    = 6'd20;
	localparam op_t OP_SLTIU   = 6'd21;
	localparam op_t OP_XORI    = 6'd22;
	localparam op_t OP_ORI     = 6'd23;
	localparam op_t OP_ANDI    = 6'd24;
	localparam op_t OP_SLLI    = 6'd25;
	localparam op_t OP_SRLI    = 6'd26;
	localparam op_t OP_SRAI    = 6'd27;
	localparam op_t OP_ADD     = 6'd28;
	localparam op_t OP_SUB     = 6'd29;
	localparam op_t OP_SLL     = 6'd30;
	localparam op_t OP_SLT     = 6'd31;
	localparam op_t OP_SLTU    = 6'd32;
	localparam op_t OP_XOR     = 6'd33;
	localparam op_t OP_SRL     = 6'd34;
	localparam op_t OP_SRA     = 6'd35;
	localparam op_t OP_OR      = 6'd36;
	localparam op_t OP_AND     = 6'd37;
	localparam op_t OP_FENCE   = 6'd38;
	localparam op_t OP_FENCE_I = 6'd39;
	localparam op_t OP_ECALL   = 6'd40;
	localparam op_t OP_EBREAK  = 6'd41;
	localparam op_t OP_CSRRW   = 6'd42;
	localparam op_t OP_CSRRS   = 6'd43;
	localparam op_t OP_CSRRC   = 6'd44;
	localparam op_t OP_CSRRWI  = 6'd45;
	localparam op_t OP_CSRRSI  = 6'd46;
	localparam op_t OP_CSRRCI  = 6'd47;

	typedef enum logic [3:0] {
		IMM_ZERO,
		IMM_I,
		IMM_S,
		IMM_B,
		IMM_U,
		IMM_J,
		IMM_SHAMT,
		IMM_CSR,
		IMM_ONE
	} imm_sel_t;

	// decoded control for one word, immediate still unbuilt
	typedef struct packed {
		logic       ok;
		fmt_t       fmt;
		op_t        op;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [2:0] f3;
		logic [6:0] f7;
		imm_sel_t   imm_sel;
	} dec_t;

	function automatic op_t branch_op(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_BEQ;
			3'd1: r = OP_BNE;
			3'd4: r = OP_BLT;
			3'd5: r = OP_BGE;
			3'd6: r = OP_BLTU;
			3'd7: r = OP_BGEU;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic op_t load_op(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_LB;
			3'd1: r = OP_LH;
			3'd2: r = OP_LW;
			3'd4: r = OP_LBU;
			3'd5: r = OP_LHU;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic op_t store_op(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_SB;
			3'd1: r = OP_SH;
			3'd2: r = OP_SW;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	// non-shift immediate ALU ops
	function automatic op_t opimm_op(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_ADDI;
			3'd2: r = OP_SLTI;
			3'd3: r = OP_SLTIU;
			3'd4: r = OP_XORI;
			3'd6: r = OP_ORI;
			3'd7: r = OP_ANDI;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic op_t alu_op(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_ADD;
			3'd1: r = OP_SLL;
			3'd2: r = OP_SLT;
			3'd3: r = OP_SLTU;
			3'd4: r = OP_XOR;
			3'd5: r = OP_SRL;
			3'd6: r = OP_OR;
			default: r = OP_AND;
		endcase
		return r;
	endfunction

	function automatic op_t csr_op(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd1: r = OP_CSRRW;
			3'd2: r = OP_CSRRS;
			3'd3: r = OP_CSRRC;
			3'd5: r = OP_CSRRWI;
			3'd6: r = OP_CSRRSI;
			3'd7: r = OP_CSRRCI;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

endpackage

@@ design/rv32i_instruction_decoder_unit.sv @@
// RV32I instruction decoder. Pulse start with a word on instr_word; busy is
// never raised, so a word may be issued in every cycle. Each accepted word
// gives exactly one result through the input register and then the result
// register, shown for one cycle with done high; the receiver cannot stall,
// so it must take the word in that cycle. Throughput is one word per clock;
// results come out in issue order. Words that are not a supported RV32I
// encoding come back with decode_ok low and every other field zero.
module rv32i_instruction_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instr_word,
	output logic        done,
	output logic        decode_ok,
	output logic [2:0]  format_code,
	output logic [5:0]  op_code,
	output logic [4:0]  dest_reg,
	output logic [4:0]  src1_reg,
	output logic [4:0]  src2_reg,
	output logic [2:0]  funct3_field,
	output logic [6:0]  funct7_field,
	output logic signed [31:0] immediate
);
	import rvid_pkg::*;

	// stage 1: captured word
	logic        valid_s1;
	logic [31:0] word_s1;

	// stage 2: result register
	logic        valid_s2;
	dec_t        dec_s2;
	logic [31:0] imm_s2;

	dec_t        dec;
	logic [31:0] imm;

	// pipeline never stalls: the result side cannot push back
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			word_s1 <= instr_word;
		end
		if (valid_s1) begin
			dec_s2 <= dec;
			imm_s2 <= imm;
		end
	end

	rvid_decode u_decode (
		.word (word_s1),
		.dec  (dec)
	);

	// decode already forces IMM_ZERO on unsupported words
	rvid_imm_gen u_imm_gen (
		.word (word_s1),
		.sel  (dec.imm_sel),
		.imm  (imm)
	);

	assign done         = valid_s2;
	assign decode_ok    = dec_s2.ok;
	assign format_code  = dec_s2.fmt;
	assign op_code      = dec_s2.op;
	assign dest_reg     = dec_s2.rd;
	assign src1_reg     = dec_s2.rs1;
	assign src2_reg     = dec_s2.rs2;
	assign funct3_field = dec_s2.f3;
	assign funct7_field = dec_s2.f7;
	assign immediate    = imm_s2;

endmodule

@@ design/rvid_decode.sv @@
// Opcode/funct classification and register field selection.
module rvid_decode (
	input  logic [31:0]   word,
	output rvid_pkg::dec_t dec
);
	import rvid_pkg::*;

	logic [6:0] opc;
	logic [4:0] rd, rs1, rs2;
	logic [2:0] f3;
	logic [6:0] f7;
	dec_t       raw;

	assign opc = word[6:0];
	assign rd  = word[11:7];
	assign f3  = word[14:12];
	assign rs1 = word[19:15];
	assign rs2 = word[24:20];
	assign f7  = word[31:25];

	always_comb begin
		raw = '0;
		raw.fmt = FMT_NONE;
		raw.op = OP_NONE;
		raw.imm_sel = IMM_ZERO;
		unique case (opc)
			OPC_LUI, OPC_AUIPC: begin
				raw.fmt = FMT_U;
				raw.op = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
				raw.rd = rd;
				raw.imm_sel = IMM_U;
			end
			OPC_JAL: begin
				raw.fmt = FMT_J;
				raw.op = OP_JAL;
				raw.rd = rd;
				raw.imm_sel = IMM_J;
			end
			OPC_JALR: begin
				if (f3 == 3'd0) begin
					raw.fmt = FMT_I;
					raw.op = OP_JALR;
					raw.rd = rd;
					raw.rs1 = rs1;
					raw.imm_sel = IMM_I;
				end
			end
			OPC_BRANCH: begin
				raw.fmt = FMT_B;
				raw.op = branch_op(f3);
				raw.rs1 = rs1;
				raw.rs2 = rs2;
				raw.f3 = f3;
				raw.imm_sel = IMM_B;
			end
			OPC_LOAD: begin
				raw.fmt = FMT_I;
				raw.op = load_op(f3);
				raw.rd = rd;
				raw.rs1 = rs1;
				raw.f3 = f3;
				raw.imm_sel = IMM_I;
			end
			OPC_STORE: begin
				// rd slot holds imm[4:0] and is passed on as extracted
				raw.fmt = FMT_S;
				raw.op = store_op(f3);
				raw.rd = rd;
				raw.rs1 = rs1;
				raw.rs2 = rs2;
				raw.f3 = f3;
				raw.imm_sel = IMM_S;
			end
			OPC_OPIMM: begin
				raw.fmt = FMT_I;
				raw.rd = rd;
				raw.rs1 = rs1;
				raw.f3 = f3;
				if (f3 == 3'd1) begin
					raw.op = (f7 == F7_BASE) ? OP_SLLI : OP_NONE;
					raw.f7 = f7;
					raw.imm_sel = IMM_SHAMT;
				end else if (f3 == 3'd5) begin
					raw.op = (f7 == F7_BASE) ? OP_SRLI :
						((f7 == F7_ALT) ? OP_SRAI : OP_NONE);
					raw.f7 = f7;
					raw.imm_sel = IMM_SHAMT;
				end else begin
					raw.op = opimm_op(f3);
					raw.imm_sel = IMM_I;
				end
			end
			OPC_OP: begin
				raw.fmt = FMT_R;
				raw.rd = rd;
				raw.rs1 = rs1;
				raw.rs2 = rs2;
				raw.f3 = f3;
				raw.f7 = f7;
				if (f7 == F7_BASE) begin
					raw.op = alu_op(f3);
				end else if (f7 == F7_ALT) begin
					raw.op = (f3 == 3'd0) ? OP_SUB : ((f3 == 3'd5) ? OP_SRA : OP_NONE);
				end
			end
			OPC_MISCMEM: begin
				if (f3[2:1] == 2'b00) begin
					raw.fmt = FMT_I;
					raw.op = f3[0] ? OP_FENCE_I : OP_FENCE;
					raw.rd = rd;
					raw.rs1 = rs1;
					raw.f3 = f3;
				end
			end
			OPC_SYSTEM: begin
				raw.fmt = FMT_I;
				if (f3 == 3'd0) begin
					// only the two exact privileged words; register and funct fields stay zero
					if (word == WORD_ECALL) begin
						raw.op = OP_ECALL;
					end else if (word == WORD_EBREAK) begin
						raw.op = OP_EBREAK;
						raw.imm_sel = IMM_ONE;
					end
				end else begin
					raw.op = csr_op(f3);
					raw.rd = rd;
					raw.rs1 = rs1;
					raw.f3 = f3;
					raw.imm_sel = IMM_CSR;
				end
			end
			default: begin
				raw.op = OP_NONE;
			end
		endcase
	end

	// unsupported encodings give all zero
	always_comb begin
		if (raw.op != OP_NONE) begin
			dec = raw;
			dec.ok = 1'b1;
		end else begin
			dec = '0;
			dec.fmt = FMT_NONE;
			dec.imm_sel = IMM_ZERO;
		end
	end

endmodule

@@ design/rvid_imm_gen.sv @@
// Immediate assembly per format.
module rvid_imm_gen (
	input  logic [31:0]       word,
	input  rvid_pkg::imm_sel_t sel,
	output logic [31:0]       imm
);
	import rvid_pkg::*;

	always_comb begin
		unique case (sel)
			IMM_I:     imm = {{20{word[31]}}, word[31:20]};
			IMM_S:     imm = {{20{word[31]}}, word[31:25], word[11:7]};
			IMM_B:     imm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
			IMM_U:     imm = {word[31:12], 12'h000};
			IMM_J:     imm = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
			IMM_SHAMT: imm = {27'd0, word[24:20]};
			IMM_CSR:   imm = {20'd0, word[31:20]};
			IMM_ONE:   imm = 32'd1;
			default:   imm = 32'd0;
		endcase
	end

endmodule

@@ design/rvid_checker.sv @@
`include "rv32i_instruction_decoder_unit_defines.svh"

// Port-level checks on the decoder.
module rvid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        decode_ok,
	input logic [2:0]  format_code,
	input logic [5:0]  op_code,
	input logic [4:0]  dest_reg,
	input logic [4:0]  src1_reg,
	input logic [4:0]  src2_reg,
	input logic [2:0]  funct3_field,
	input logic [6:0]  funct7_field,
	input logic [31:0] immediate
);

	// every accepted word yields a done strobe
	`RVID_ASSERT_NEXT(a_issue_done, start && !busy, ##1 done)

	// no result without an accepted word before it
	`RVID_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, 2))

	// rejected words carry all-zero fields
	`RVID_ASSERT_IMPL(a_reject_zero, done && !decode_ok,
		format_code == 3'd0 && op_code == 6'd0 && dest_reg == 5'd0 &&
		src1_reg == 5'd0 && src2_reg == 5'd0 && funct3_field == 3'd0 &&
		funct7_field == 7'd0 && immediate == 32'd0)

	// accepted words carry a real format and op
	`RVID_ASSERT_IMPL(a_ok_codes, done && decode_ok,
		format_code != 3'd0 && format_code <= 3'd6 && op_code != 6'd0 &&
		op_code <= 6'd47)

endmodule

bind rv32i_instruction_decoder_unit rvid_checker u_rvid_checker (.*);

@@ test/rv32i_instruction_decoder_unit_tb.sv @@
// Decoder testbench. Words go in through the start/busy handshake. Each word
// is decoded again here at the edge where it is taken, and that prediction
// waits in a queue. Every done strobe is compared, field by field, against the
// oldest prediction. The block has no registers to program, so the run is
// directed words followed by phases of random words at different idle rates.
module rv32i_instruction_decoder_unit_tb;
	import rvid_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;	// cycles with no word in or out
	localparam int TAIL_CYCLES    = 8;	// room for stray strobes after the drain
	localparam int MAX_REPORTS    = 10;

	// funct3 values that choose an alternate form through funct7
	localparam logic [2:0] F3_ADD_SUB  = 3'd0;
	localparam logic [2:0] F3_SHIFT_RT = 3'd5;

	localparam logic [6:0] MAJOR_OPCODES [0:10] = '{
		OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD,
		OPC_STORE, OPC_OPIMM, OPC_OP, OPC_MISCMEM, OPC_SYSTEM
	};

	// operation by funct3 for the branch, load, store, ALU, fence and CSR opcodes; OP_NONE marks a hole
	localparam op_t BRANCH_BY_F3 [0:7] = '{
		OP_BEQ, OP_BNE, OP_NONE, OP_NONE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU
	};
	localparam op_t LOAD_BY_F3 [0:7] = '{
		OP_LB, OP_LH, OP_LW, OP_NONE, OP_LBU, OP_LHU, OP_NONE, OP_NONE
	};
	localparam op_t STORE_BY_F3 [0:7] = '{
		OP_SB, OP_SH, OP_SW, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE
	};
	// shift entries still need their funct7 checked
	localparam op_t OPIMM_BY_F3 [0:7] = '{
		OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_ORI, OP_ANDI
	};
	localparam op_t ALU_BY_F3 [0:7] = '{
		OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND
	};
	localparam op_t ALU_ALT_BY_F3 [0:7] = '{
		OP_SUB, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_SRA, OP_NONE, OP_NONE
	};
	localparam op_t MISCMEM_BY_F3 [0:7] = '{
		OP_FENCE, OP_FENCE_I, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE
	};
	localparam op_t CSR_BY_F3 [0:7] = '{
		OP_NONE, OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_NONE, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI
	};

	typedef struct packed {
		logic        ok;
		fmt_t        fmt;
		op_t         op;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [31:0] imm;
	} decoded_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] instr_word;
	logic        done;
	logic        decode_ok;
	logic [2:0]  format_code;
	logic [5:0]  op_code;
	logic [4:0]  dest_reg;
	logic [4:0]  src1_reg;
	logic [4:0]  src2_reg;
	logic [2:0]  funct3_field;
	logic [6:0]  funct7_field;
	logic signed [31:0] immediate;

	decoded_t pending_decodes [$];	// predictions for words taken, oldest first
	int       mismatch_count = 0;
	int       quiet_cycles = 0;

	rv32i_instruction_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.instr_word   (instr_word),
		.done         (done),
		.decode_ok    (decode_ok),
		.format_code  (format_code),
		.op_code      (op_code),
		.dest_reg     (dest_reg),
		.src1_reg     (src1_reg),
		.src2_reg     (src2_reg),
		.funct3_field (funct3_field),
		.funct7_field (funct7_field),
		.immediate    (immediate)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Decode one word the way the block should. Fields are filled in per
	// opcode without regard to legality; an unknown encoding is wiped to
	// all zeros at the end, which is what the block must show for it.
	function automatic decoded_t decode_word(input logic [31:0] w);
		decoded_t   d;
		op_t        op;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [31:0] imm_i;
		d = '0;
		op = OP_NONE;
		f3 = w[14:12];
		f7 = w[31:25];
		imm_i = {{20{w[31]}}, w[31:20]};
		case (w[6:0])
			OPC_LUI, OPC_AUIPC: begin
				op = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
				d.fmt = FMT_U;
				d.rd = w[11:7];
				d.imm = {w[31:12], 12'b0};
			end
			OPC_JAL: begin
				op = OP_JAL;
				d.fmt = FMT_J;
				d.rd = w[11:7];
				d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_JALR: begin
				op = (f3 == F3_ADD_SUB) ? OP_JALR : OP_NONE;
				d.fmt = FMT_I;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.imm = imm_i;
			end
			OPC_BRANCH: begin
				// rd slot holds immediate bits here, so rd stays zero
				op = BRANCH_BY_F3[f3];
				d.fmt = FMT_B;
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.f3 = f3;
				d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			end
			OPC_LOAD: begin
				op = LOAD_BY_F3[f3];
				d.fmt = FMT_I;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.f3 = f3;
				d.imm = imm_i;
			end
			OPC_STORE: begin
				// stores still report bits 11:7 on the rd field
				op = STORE_BY_F3[f3];
				d.fmt = FMT_S;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.f3 = f3;
				d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
			end
			OPC_OPIMM: begin
				op = OPIMM_BY_F3[f3];
				d.fmt = FMT_I;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.f3 = f3;
				d.imm = imm_i;
				if (op == OP_SLLI || op == OP_SRLI) begin
					// shifts: funct7 picks the form, immediate is the shamt
					if (op == OP_SRLI && f7 == F7_ALT)
						op = OP_SRAI;
					else if (f7 != F7_BASE)
						op = OP_NONE;
					d.f7 = f7;
					d.imm = {27'b0, w[24:20]};
				end
			end
			OPC_OP: begin
				if (f7 == F7_BASE)
					op = ALU_BY_F3[f3];
				else if (f7 == F7_ALT)
					op = ALU_ALT_BY_F3[f3];
				d.fmt = FMT_R;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.f3 = f3;
				d.f7 = f7;
			end
			OPC_MISCMEM: begin
				op = MISCMEM_BY_F3[f3];
				d.fmt = FMT_I;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.f3 = f3;
			end
			OPC_SYSTEM: begin
				d.fmt = FMT_I;
				// ECALL and EBREAK only as exact words; register and funct fields stay zero
				if (w == WORD_ECALL) begin
					op = OP_ECALL;
				end else if (w == WORD_EBREAK) begin
					op = OP_EBREAK;
					d.imm = 32'd1;
				end else begin
					op = CSR_BY_F3[f3];
					d.rd = w[11:7];
					d.rs1 = w[19:15];
					d.f3 = f3;
					d.imm = {20'b0, w[31:20]};
				end
			end
			default: op = OP_NONE;
		endcase
		if (op == OP_NONE) begin
			d = '0;
		end else begin
			d.ok = 1'b1;
			d.op = op;
		end
		return d;
	endfunction

	// Mostly words with a real major opcode and random content; the rest is noise
	// and the two exact privileged words or near misses of them.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int pick;
		w = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return w;
		if (pick < 18) begin
			w = $urandom_range(0, 1) ? WORD_EBREAK : WORD_ECALL;
			if ($urandom_range(0, 1))
				w[$urandom_range(7, 31)] = ~w[$urandom_range(7, 31)];
			return w;
		end
		w[6:0] = MAJOR_OPCODES[$urandom_range(0, 10)];
		// lean funct7 toward its two legal values where it selects the op
		if ((w[6:0] == OPC_OP || w[6:0] == OPC_OPIMM) && $urandom_range(0, 9) < 8)
			w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
		return w;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endtask

	// Offer one word, optionally after random idle cycles. Called at a clock
	// edge; returns at the edge where the word was taken, with start still
	// high so back-to-back words never lower and raise it in one step.
	task automatic send_word(input logic [31:0] w, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			instr_word <= $urandom;	// ignored while start is low
			@(posedge clk);
		end
		start <= 1'b1;
		instr_word <= w;
		do @(posedge clk); while (busy);
	endtask

	// Stop offering words until every predicted result has been seen.
	task automatic drain_pipeline();
		start <= 1'b0;
		@(posedge clk);
		while (pending_decodes.size() != 0)
			@(posedge clk);
	endtask

	// Zero word, all-ones word, and the largest and smallest immediate of
	// each format, plus every register field at its top value.
	task automatic test_field_extremes();
		logic [31:0] words [0:13];
		words = '{
			32'h0000_0000, 32'hFFFF_FFFF,
			32'h7FF0_0013, 32'h8000_0013,	// ADDI +2047 / -2048
			32'h7FFF_F06F, 32'h8000_006F,	// JAL extremes
			32'h7E00_0FE3, 32'h8000_0063,	// BEQ extremes
			32'h7E00_0FA3, 32'h8000_0023,	// SB extremes
			32'hFFFF_F037, 32'h0000_0037,	// LUI
			32'hFFF0_1073,			// CSRRW, top CSR index
			32'h01FF_8FB3			// ADD x31, x31, x31
		};
		foreach (words[i])
			send_word(words[i], 0);
	endtask

	// Every major opcode with every funct3, random remaining bits; the ALU
	// forms get the base funct7, and the alternate one too at funct3 0 and 5.
	task automatic test_opcode_sweep();
		logic [31:0] w;
		foreach (MAJOR_OPCODES[i]) begin
			for (int f3 = 0; f3 < 8; f3++) begin
				w = $urandom;
				w[6:0] = MAJOR_OPCODES[i];
				w[14:12] = 3'(f3);
				if (w[6:0] == OPC_OP || w[6:0] == OPC_OPIMM)
					w[31:25] = F7_BASE;
				send_word(w, 0);
				if ((w[6:0] == OPC_OP || w[6:0] == OPC_OPIMM) &&
						(w[14:12] == F3_ADD_SUB || w[14:12] == F3_SHIFT_RT)) begin
					w[31:25] = F7_ALT;
					send_word(w, 0);
				end
			end
		end
	endtask

	// Privileged exact words and their neighbors, SYSTEM funct3 4, illegal
	// funct7, shift with the wrong funct7, SRAI by 31, a store with funct3 3, a fence and JALR funct3 1.
	task automatic test_special_words();
		logic [31:0] words [0:11];
		words = '{
			WORD_ECALL, WORD_EBREAK,
			32'h0000_00F3,			// ECALL with rd set
			32'h0010_8073,			// EBREAK with rs1 set
			32'h3020_0073,			// other privileged word
			32'h0000_4073,			// SYSTEM funct3 4
			32'h0200_0033,			// OP with foreign funct7
			32'h4000_1013,			// SLLI with alternate funct7
			32'h41F0_5013,			// SRAI by 31
			32'h0000_3023,			// store funct3 3
			32'h0FF0_000F,			// FENCE
			32'h0000_1067			// JALR funct3 1
		};
		foreach (words[i])
			send_word(words[i], 0);
	endtask

	task automatic test_random_words(input int count, input int idle_pct);
		repeat (count)
			send_word(random_word(), idle_pct);
	endtask

	// Random traffic that stops once until the block is empty, then resumes.
	task automatic test_pause_and_resume(input int count, input int idle_pct);
		test_random_words(count / 2, idle_pct);
		drain_pipeline();
		test_random_words(count - count / 2, idle_pct);
	endtask

	// Check each done strobe against the oldest prediction, then record any
	// word taken at this same edge. Both sides read values from before the
	// edge, since everything is driven with nonblocking assignments.
	always @(posedge clk) begin : check_results
		decoded_t want;
		decoded_t got;
		if (arst_n) begin
			if (done) begin
				if (pending_decodes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result strobe with no word outstanding");
				end else begin
					want = pending_decodes.pop_front();
					got.ok = decode_ok;
					got.fmt = fmt_t'(format_code);
					got.op = op_code;
					got.rd = dest_reg;
					got.rs1 = src1_reg;
					got.rs2 = src2_reg;
					got.f3 = funct3_field;
					got.f7 = funct7_field;
					got.imm = immediate;
					if (got.ok !== want.ok)
						note_mismatch("decode_ok", 32'(want.ok), 32'(got.ok));
					if (got.fmt !== want.fmt)
						note_mismatch("format_code", 32'(want.fmt), 32'(got.fmt));
					if (got.op !== want.op)
						note_mismatch("op_code", 32'(want.op), 32'(got.op));
					if (got.rd !== want.rd)
						note_mismatch("dest_reg", 32'(want.rd), 32'(got.rd));
					if (got.rs1 !== want.rs1)
						note_mismatch("src1_reg", 32'(want.rs1), 32'(got.rs1));
					if (got.rs2 !== want.rs2)
						note_mismatch("src2_reg", 32'(want.rs2), 32'(got.rs2));
					if (got.f3 !== want.f3)
						note_mismatch("funct3_field", 32'(want.f3), 32'(got.f3));
					if (got.f7 !== want.f7)
						note_mismatch("funct7_field", 32'(want.f7), 32'(got.f7));
					if (got.imm !== want.imm)
						note_mismatch("immediate", want.imm, got.imm);
				end
			end
			if (start && !busy)
				pending_decodes.push_back(decode_word(instr_word));
		end
	end

	// Watchdog: end the run if neither a word nor a result moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("rv32i_instruction_decoder_unit_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		instr_word = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_opcode_sweep();
		test_special_words();

		// idle phases: none, sender 72%, receiver phase (it cannot stall,
		// so no idling), then sender 16%
		test_random_words(310, 0);
		test_pause_and_resume(310, 72);
		test_random_words(310, 0);
		test_random_words(310, 16);

		drain_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_decodes.size() != 0)
			mismatch_count++;

		if (mismatch_count == 0)
			$display("rv32i_instruction_decoder_unit_tb OK");
		else
			$display("rv32i_instruction_decoder_unit_tb NOT OK");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+design
design/rvid_pkg.sv
design/rvid_decode.sv
design/rvid_imm_gen.sv
design/rv32i_instruction_decoder_unit.sv
design/rvid_checker.sv
test/rv32i_instruction_decoder_unit_tb.sv
